// ===== rtl/rgb_to_hsb_convert_assert.svh =====
// ----------------------------------------------------------------------------
// rgb_to_hsb_convert assertion macros
// Shared concurrent assertion forms, sampled on i_clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSB_CONVERT_ASSERT_SVH
`define RGB_TO_HSB_CONVERT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTBC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold a fixed number of cycles after the antecedent.
`define RTBC_ASSERT_LATER(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##dly (cons)) else $error(msg);

`endif

// ===== rtl/rtbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtbc_pkg
// Shared types, constants and the divider step for the RGB to HSB converter.
// ----------------------------------------------------------------------------
package rtbc_pkg;

    // Quotient width of both dividers and how it is spread over the stages.
    localparam int QuoWidth        = 8;
    localparam int DivBitsPerStage = 2;
    localparam int DivStages       = QuoWidth / DivBitsPerStage;

    // Hue branch codes, in the order in which they take priority.
    localparam logic [1:0] BR_RED   = 2'd0;
    localparam logic [1:0] BR_GREEN = 2'd1;
    localparam logic [1:0] BR_BLUE  = 2'd2;

    // Hue offsets and the full turn, in degrees.
    localparam logic [8:0] HUE_OFS_GREEN = 9'd120;
    localparam logic [8:0] HUE_OFS_BLUE  = 9'd240;
    localparam logic [8:0] HUE_TURN      = 9'd360;

    // 100 * 32897: brightness is (mx * BRI_MAGIC) >> 23, equal to 100*mx/255.
    localparam logic [21:0] BRI_MAGIC = 22'd3289700;
    localparam int          BriShift  = 23;

    // Pixel information that rides alongside the dividers.
    typedef struct packed {
        logic [1:0] branch;
        logic       neg;
        logic       grey;
        logic       black;
        logic [6:0] bri;
    } t_side;

    // One divider lane: partial remainder, dividend bits still to come, quotient.
    typedef struct packed {
        logic [7:0]          rem;
        logic [7:0]          low;
        logic [QuoWidth-1:0] quo;
    } t_div_lane;

    // Restoring division, DivBitsPerStage quotient bits at a time.
    function automatic t_div_lane div_step(t_div_lane a, logic [7:0] dv);
        t_div_lane  res;
        logic [8:0] trial;
        res = a;
        for (int i = 0; i < DivBitsPerStage; i++) begin
            trial = {res.rem, res.low[7]};
            res.low = {res.low[6:0], 1'b0};
            if (trial >= {1'b0, dv}) begin
                trial   = trial - {1'b0, dv};
                res.quo = {res.quo[QuoWidth-2:0], 1'b1};
            end else begin
                res.quo = {res.quo[QuoWidth-2:0], 1'b0};
            end
            res.rem = trial[7:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/rtbc_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtbc_divider
// Two-lane pipelined restoring divider, 16-bit dividend by 8-bit divisor,
// for quotients below 256. Side information travels with each request.
// ----------------------------------------------------------------------------
module rtbc_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [15:0]                    i_hue_num,
    input  logic [7:0]                     i_hue_den,
    input  logic [15:0]                    i_sat_num,
    input  logic [7:0]                     i_sat_den,
    input  rtbc_pkg::t_side                i_side,
    output logic                           o_valid,
    output logic [rtbc_pkg::QuoWidth-1:0]  o_hue_quo,
    output logic                           o_hue_rem_nz,
    output logic [rtbc_pkg::QuoWidth-1:0]  o_sat_quo,
    output rtbc_pkg::t_side                o_side
);
    import rtbc_pkg::*;

    logic      r_vld  [DivStages];
    t_div_lane r_hl   [DivStages];
    logic [7:0] r_hd  [DivStages];
    t_div_lane r_sl   [DivStages];
    logic [7:0] r_sd  [DivStages];
    t_side     r_side [DivStages];

    logic      w_vld_in  [DivStages];
    t_div_lane w_hl_in   [DivStages];
    logic [7:0] w_hd_in  [DivStages];
    t_div_lane w_sl_in   [DivStages];
    logic [7:0] w_sd_in  [DivStages];
    t_side     w_side_in [DivStages];

    for (genvar s = 0; s < DivStages; s++) begin : g_stage
        // Stage input: the new request for the first stage, else the stage before.
        if (s == 0) begin : g_first
            assign w_vld_in[s]  = i_valid;
            assign w_hl_in[s]   = '{rem: i_hue_num[15:8], low: i_hue_num[7:0], quo: '0};
            assign w_hd_in[s]   = i_hue_den;
            assign w_sl_in[s]   = '{rem: i_sat_num[15:8], low: i_sat_num[7:0], quo: '0};
            assign w_sd_in[s]   = i_sat_den;
            assign w_side_in[s] = i_side;
        end else begin : g_next
            assign w_vld_in[s]  = r_vld[s-1];
            assign w_hl_in[s]   = r_hl[s-1];
            assign w_hd_in[s]   = r_hd[s-1];
            assign w_sl_in[s]   = r_sl[s-1];
            assign w_sd_in[s]   = r_sd[s-1];
            assign w_side_in[s] = r_side[s-1];
        end

        // Valid bit of the stage.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= w_vld_in[s];
            end
        end

        // Quotient bits of this stage for both lanes.
        always_ff @(posedge i_clk) begin
            r_hl[s]   <= div_step(w_hl_in[s], w_hd_in[s]);
            r_hd[s]   <= w_hd_in[s];
            r_sl[s]   <= div_step(w_sl_in[s], w_sd_in[s]);
            r_sd[s]   <= w_sd_in[s];
            r_side[s] <= w_side_in[s];
        end
    end

    assign o_valid      = r_vld[DivStages-1];
    assign o_hue_quo    = r_hl[DivStages-1].quo;
    assign o_hue_rem_nz = |r_hl[DivStages-1].rem;
    assign o_sat_quo    = r_sl[DivStages-1].quo;
    assign o_side       = r_side[DivStages-1];

endmodule

// ===== rtl/rgb_to_hsb_convert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsb_convert
// Converts one 8-bit RGB pixel to hue in degrees and saturation and
// brightness in whole percent.
// ----------------------------------------------------------------------------
// The block takes one pixel request in every clock cycle and never raises
// busy. Each request gives exactly one result, shown for one cycle with
// o_done high, after passing through one input register, one stage that
// finds the largest and smallest channel and forms the dividends, four
// divider stages that each resolve two quotient bits, and the output
// register. Results leave in request order and cannot be held off, so the
// receiver must take every result in the cycle it appears.
module rgb_to_hsb_convert (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_done,
    output logic [8:0] o_hue,
    output logic [6:0] o_saturation,
    output logic [6:0] o_brightness
);
    import rtbc_pkg::*;

    `include "rgb_to_hsb_convert_assert.svh"

    // Input register.
    logic       r_s1_vld;
    logic [7:0] r_s1_r, r_s1_g, r_s1_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_r <= i_red;
        r_s1_g <= i_green;
        r_s1_b <= i_blue;
    end

    assign busy = 1'b0;

    // Largest and smallest channel, hue branch and the hue numerator.
    logic [7:0] mx, mn, d, mag;
    logic [8:0] num;
    logic [1:0] branch;

    always_comb begin
        mx = r_s1_r;
        mn = r_s1_r;
        if (r_s1_g > mx) mx = r_s1_g;
        if (r_s1_b > mx) mx = r_s1_b;
        if (r_s1_g < mn) mn = r_s1_g;
        if (r_s1_b < mn) mn = r_s1_b;
        d = mx - mn;
        priority if (r_s1_r == mx) begin
            branch = BR_RED;
            num    = {1'b0, r_s1_g} - {1'b0, r_s1_b};
        end else if (r_s1_g == mx) begin
            branch = BR_GREEN;
            num    = {1'b0, r_s1_b} - {1'b0, r_s1_r};
        end else begin
            branch = BR_BLUE;
            num    = {1'b0, r_s1_r} - {1'b0, r_s1_g};
        end
        mag = num[8] ? 8'(-num) : num[7:0];
    end

    // Stage two: dividends 60*|num| and 100*d by shifts and adds.
    logic        r_s2_vld;
    logic [15:0] r_s2_hue_num;
    logic [15:0] r_s2_sat_num;
    logic [7:0]  r_s2_d, r_s2_mx;
    logic [1:0]  r_s2_branch;
    logic        r_s2_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_hue_num <= {2'b00, mag, 6'b0} - {6'b0, mag, 2'b0};
        r_s2_sat_num <= {2'b00, d, 6'b0} + {3'b000, d, 5'b0} + {6'b0, d, 2'b0};
        r_s2_d       <= d;
        r_s2_mx      <= mx;
        r_s2_branch  <= branch;
        r_s2_neg     <= num[8];
    end

    // Brightness by a reciprocal multiply, registered inside the divider.
    logic [29:0] bri_prod;
    t_side       side_in;

    assign bri_prod = {22'd0, r_s2_mx} * {8'd0, BRI_MAGIC};

    always_comb begin
        side_in.branch = r_s2_branch;
        side_in.neg    = r_s2_neg;
        side_in.grey   = (r_s2_d == 8'd0);
        side_in.black  = (r_s2_mx == 8'd0);
        side_in.bri    = bri_prod[BriShift+6:BriShift];
    end

    // Hue and saturation dividers.
    logic                div_vld;
    logic [QuoWidth-1:0] hue_quo, sat_quo;
    logic                hue_rem_nz;
    t_side               side_out;

    rtbc_divider u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_s2_vld),
        .i_hue_num    (r_s2_hue_num),
        .i_hue_den    (r_s2_d),
        .i_sat_num    (r_s2_sat_num),
        .i_sat_den    (r_s2_mx),
        .i_side       (side_in),
        .o_valid      (div_vld),
        .o_hue_quo    (hue_quo),
        .o_hue_rem_nz (hue_rem_nz),
        .o_sat_quo    (sat_quo),
        .o_side       (side_out)
    );

    // Hue from the quotient: offset plus or minus, truncation toward zero for a negative red hue, floor for the others.
    logic [8:0] q9, n_hue;
    logic [8:0] ofs;

    always_comb begin
        q9 = {1'b0, hue_quo};
        unique case (side_out.branch)
            BR_GREEN: ofs = HUE_OFS_GREEN;
            BR_BLUE:  ofs = HUE_OFS_BLUE;
            default:  ofs = 9'd0;
        endcase
        if (side_out.grey) begin
            n_hue = 9'd0;
        end else if (side_out.branch == BR_RED) begin
            if (side_out.neg && (q9 != 9'd0)) begin
                n_hue = HUE_TURN - q9;
            end else begin
                n_hue = q9;
            end
        end else if (side_out.neg) begin
            n_hue = ofs - q9 - {8'd0, hue_rem_nz};
        end else begin
            n_hue = ofs + q9;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_hue        <= n_hue;
        o_saturation <= side_out.black ? 7'd0 : sat_quo[6:0];
        o_brightness <= side_out.bri;
    end

    // Every request gives its result on o_done.
    `RTBC_ASSERT_LATER(a_latency, start && !busy, 7, o_done, "result missing after request")
    // Hue stays within one turn.
    `RTBC_ASSERT_SAME(a_hue_range, o_done, o_hue < HUE_TURN, "hue out of range")
    // Percentages stay at or below one hundred.
    `RTBC_ASSERT_SAME(a_sat_range, o_done, o_saturation <= 7'd100, "saturation out of range")
    `RTBC_ASSERT_SAME(a_bri_range, o_done, o_brightness <= 7'd100, "brightness out of range")

endmodule

// ===== tb/tb_rgb_to_hsb_convert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsb_convert
// Self-checking bench for the RGB to HSB pixel converter. Pixel requests go
// in through start/busy, and every o_done strobe is checked field by field
// against an in-order queue of hue, saturation and brightness values that a
// behavioral integer model of the conversion predicts.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsb_convert;

    localparam int ClkHalf     = 4;
    localparam int ResetCycles = 11;
    localparam int SettleTime  = 12;      // extra wait after the last result is back
    localparam int CycleLimit  = 40000;
    localparam int IdlePercent = 36;

    // One converted pixel, at the widths of the result ports.
    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] bri;
    } t_hsb;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [7:0] i_red;
    logic [7:0] i_green;
    logic [7:0] i_blue;
    logic       o_done;
    logic [8:0] o_hue;
    logic [6:0] o_saturation;
    logic [6:0] o_brightness;

    t_hsb hsb_expect_q[$];
    int   pixels_sent     = 0;
    int   results_checked = 0;
    int   mismatch_count  = 0;
    int   cycle_count     = 0;

    rgb_to_hsb_convert dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_done       (o_done),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    // Free-running clock, 8 ns period.
    always begin
        i_clk = 1'b0;
        #ClkHalf;
        i_clk = 1'b1;
        #ClkHalf;
    end

    // Watchdog: a hung pipeline ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Integer HSB conversion. Ties for the largest channel go to red, then
    // green, then blue. The red branch truncates toward zero and wraps a
    // negative angle; the other branches are always positive.
    function automatic t_hsb predict_hsb(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
        int   r;
        int   g;
        int   b;
        int   mx;
        int   mn;
        int   d;
        int   hue;
        t_hsb res;
        r  = r8;
        g  = g8;
        b  = b8;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (d == 0) begin
            hue = 0;
        end else if (r == mx) begin
            hue = (60 * (g - b)) / d;
        end else if (g == mx) begin
            hue = (60 * (b - r) + 120 * d) / d;
        end else begin
            hue = (60 * (r - g) + 240 * d) / d;
        end
        if (hue < 0) hue += 360;
        res.hue = hue[8:0];
        res.sat = (mx == 0) ? 7'd0 : 7'((100 * d) / mx);
        res.bri = 7'((100 * mx) / 255);
        return res;
    endfunction

    // Result checker: every strobe must match the oldest pending request.
    always @(posedge i_clk) begin
        t_hsb want;
        if (i_rst_n && o_done) begin
            if (hsb_expect_q.size() == 0) begin
                $error("result strobe with no request pending: hue %0d sat %0d bri %0d",
                       o_hue, o_saturation, o_brightness);
                mismatch_count++;
            end else begin
                want = hsb_expect_q.pop_front();
                results_checked++;
                if (o_hue !== want.hue) begin
                    $error("hue: expected %0d, actual %0d", want.hue, o_hue);
                    mismatch_count++;
                end
                if (o_saturation !== want.sat) begin
                    $error("saturation: expected %0d, actual %0d", want.sat, o_saturation);
                    mismatch_count++;
                end
                if (o_brightness !== want.bri) begin
                    $error("brightness: expected %0d, actual %0d", want.bri, o_brightness);
                    mismatch_count++;
                end
            end
        end
    end

    // Present one pixel and hold it until the request is taken. Start stays
    // high afterwards so a following request can go out back to back.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        start   <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        hsb_expect_q.push_back(predict_hsb(r, g, b));
        pixels_sent++;
    endtask

    // Random sender idling: each cycle stays idle with the idle percentage,
    // so about that share of all cycles carries no request.
    task automatic maybe_idle();
        while ($urandom_range(0, 99) < IdlePercent) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every pending result has come back.
    task automatic wait_all_results();
        start <= 1'b0;
        while (hsb_expect_q.size() != 0) @(posedge i_clk);
        repeat (SettleTime) @(posedge i_clk);
    endtask

    // Pixel generator biased toward greys, ties for the maximum and the rails.
    task automatic random_pixel(output logic [7:0] r, output logic [7:0] g,
                                output logic [7:0] b);
        logic [7:0] hi;
        logic [7:0] lo;
        r = 8'($urandom_range(0, 255));
        g = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: begin
                g = r;
                b = r;
            end
            1: begin
                hi = 8'($urandom_range(0, 255));
                lo = 8'($urandom_range(0, hi));
                case ($urandom_range(0, 2))
                    0: begin r = hi; g = hi; b = lo; end
                    1: begin r = hi; g = lo; b = hi; end
                    default: begin r = lo; g = hi; b = hi; end
                endcase
            end
            2: begin
                r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: ;
        endcase
    endtask

    // Rails, greys, primaries, ties in branch priority and negative red hues.
    task automatic test_directed_corners();
        send_pixel(8'd0,   8'd0,   8'd0);    // black
        send_pixel(8'd255, 8'd255, 8'd255);  // white
        send_pixel(8'd128, 8'd128, 8'd128);  // mid grey
        send_pixel(8'd255, 8'd0,   8'd0);    // pure red
        maybe_idle();
        send_pixel(8'd0,   8'd255, 8'd0);    // pure green
        send_pixel(8'd0,   8'd0,   8'd255);  // pure blue
        send_pixel(8'd255, 8'd255, 8'd0);    // red and green tie
        send_pixel(8'd255, 8'd0,   8'd255);  // red and blue tie, wraps to 300
        maybe_idle();
        send_pixel(8'd0,   8'd255, 8'd255);  // green and blue tie
        send_pixel(8'd255, 8'd0,   8'd10);   // small negative red hue
        send_pixel(8'd200, 8'd100, 8'd150);  // exact negative red hue
        send_pixel(8'd1,   8'd0,   8'd1);    // smallest spread, wraps
        send_pixel(8'd200, 8'd50,  8'd50);   // red with equal green and blue
        maybe_idle();
        send_pixel(8'd1,   8'd0,   8'd0);    // darkest non-black
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd10,  8'd20,  8'd30);
        send_pixel(8'd30,  8'd10,  8'd20);
        send_pixel(8'd20,  8'd30,  8'd10);
        send_pixel(8'd255, 8'd1,   8'd0);
    endtask

    // A short burst, then the sender holds off until the pipeline is empty.
    task automatic test_pause_until_drained();
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        repeat (20) begin
            random_pixel(r, g, b);
            send_pixel(r, g, b);
        end
        wait_all_results();
    endtask

    // A long stretch of back-to-back requests with no gaps at all.
    task automatic test_gapless_stream();
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        repeat (130) begin
            random_pixel(r, g, b);
            send_pixel(r, g, b);
        end
    endtask

    // Random pixels with random sender gaps.
    task automatic test_random_with_gaps();
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        repeat (300) begin
            maybe_idle();
            random_pixel(r, g, b);
            send_pixel(r, g, b);
        end
    endtask

    // Test sequence.
    initial begin
        start   <= 1'b0;
        i_red   <= 8'd0;
        i_green <= 8'd0;
        i_blue  <= 8'd0;
        i_rst_n <= 1'b0;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_pause_until_drained();
        test_gapless_stream();
        test_random_with_gaps();
        wait_all_results();

        $display("Sent %0d pixel requests: corners, ties, greys, rails and random colors,",
                 pixels_sent);
        $display("with and without sender gaps; %0d results compared, %0d mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
